@@ sv/assert_macros.svh @@
// Assertion helpers included by the RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

@@ sv/akf_pkg.sv @@
package akf_pkg;

   localparam int NUM_AXES    = 2;
   localparam int AXIS_W      = 1;
   localparam int WORD_W      = 32;
   localparam int NOISE_W     = 31;
   localparam int DT_W        = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int MAG_W       = 48;
   localparam int MUL_CYCLES  = 32;
   localparam int DIV_CYCLES  = 48;
   localparam int CNT_W       = 6;

   typedef logic signed [WORD_W-1:0] q_type;

   localparam logic [CSR_IDX_W-1:0] REG_NOISE_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_BIAS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP   = 2'd3;

   localparam logic [NOISE_W-1:0] NOISE_RESET = 31'd32768;
   localparam logic [DT_W-1:0]    DT_RESET    = 17'd262;
   localparam q_type              Q_ONE       = 32'sd65536;
   localparam q_type              Q_MAX       = 32'sh7FFF_FFFF;
   localparam q_type              Q_MIN       = 32'sh8000_0000;

   function automatic q_type sat_sum(input logic signed [WORD_W:0] s);
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? Q_MIN : Q_MAX;
      end
      return q_type'(s[WORD_W-1:0]);
   endfunction

   function automatic q_type qadd(input q_type a, input q_type b);
      return sat_sum({a[WORD_W-1], a} + {b[WORD_W-1], b});
   endfunction

   function automatic q_type qsub(input q_type a, input q_type b);
      return sat_sum({a[WORD_W-1], a} - {b[WORD_W-1], b});
   endfunction

   function automatic logic [WORD_W-1:0] mag(input q_type a);
      return a[WORD_W-1] ? (~a + 32'd1) : a;
   endfunction

   function automatic q_type sat_mag(input logic [MAG_W-1:0] m, input logic neg);
      if (neg) begin
         if (m > 48'h0000_8000_0000) begin
            return Q_MIN;
         end
         return q_type'(~m[WORD_W-1:0] + 32'd1);
      end
      if (m > 48'h0000_7FFF_FFFF) begin
         return Q_MAX;
      end
      return q_type'(m[WORD_W-1:0]);
   endfunction

endpackage

@@ sv/angle_kalman_filter_two_state.sv @@
// Channel   Direction  Handshake              Word
// req       in         req_valid/req_ready    axis, measured angle, measured rate
// rsp       out        rsp_valid/rsp_ready    axis, filtered angle, corrected rate
// csr       in         csr_valid/csr_ready    register index, data
//
// One item runs ten shift-add multiplies and two restoring divisions in turn on one
// shared serial unit, each with a load step, a serial run and an update step, then
// one write-back. A new item is accepted only after the previous write-back.
// Reset is synchronous and restores the registers and both filter copies.
// A new item is accepted while the previous result waits in the output register.
// A stalled output holds the sequencer before its final write-back.
`include "assert_macros.svh"

module angle_kalman_filter_two_state (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [akf_pkg::AXIS_W-1:0]           req_axis,
   input  logic signed [akf_pkg::WORD_W-1:0]    req_angle_meas,
   input  logic signed [akf_pkg::WORD_W-1:0]    req_gyro_meas,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [akf_pkg::AXIS_W-1:0]           rsp_axis_out,
   output logic signed [akf_pkg::WORD_W-1:0]    rsp_angle_est,
   output logic signed [akf_pkg::WORD_W-1:0]    rsp_rate_est,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [akf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [akf_pkg::WORD_W-1:0]           csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_APPLY, S_WB} state_type;
   typedef enum logic [3:0] {
      OP_ANG, OP_PAA, OP_PAB, OP_PBB, OP_K0, OP_K1,
      OP_C0, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   logic [akf_pkg::NOISE_W-1:0] qa_ff, qb_ff, rn_ff;
   logic [akf_pkg::DT_W-1:0]    dt_ff;

   akf_pkg::q_type ang_mem_ff  [akf_pkg::NUM_AXES];
   akf_pkg::q_type bias_mem_ff [akf_pkg::NUM_AXES];
   akf_pkg::q_type paa_mem_ff  [akf_pkg::NUM_AXES];
   akf_pkg::q_type pab_mem_ff  [akf_pkg::NUM_AXES];
   akf_pkg::q_type pba_mem_ff  [akf_pkg::NUM_AXES];
   akf_pkg::q_type pbb_mem_ff  [akf_pkg::NUM_AXES];

   logic [akf_pkg::AXIS_W-1:0] ax_ff, ax_in;
   akf_pkg::q_type meas_ff, gyro_ff, ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff;
   akf_pkg::q_type err_ff, e_ff, k0_ff, k1_ff, t0_ff, t1_ff;

   logic                         div_ff, neg_ff, den_zero_ff;
   logic [akf_pkg::CNT_W-1:0]    cnt_ff;
   logic [akf_pkg::WORD_W-1:0]   opnd_ff;
   logic [akf_pkg::WORD_W:0]     hi_ff;
   logic [akf_pkg::WORD_W-1:0]   lo_ff;
   logic [akf_pkg::WORD_W-1:0]   rem_ff;
   logic [akf_pkg::MAG_W-1:0]    quo_ff;

   logic                         rsp_valid_ff;
   logic [akf_pkg::AXIS_W-1:0]   rsp_axis_ff;
   akf_pkg::q_type               rsp_angle_ff, rsp_rate_ff;

   akf_pkg::q_type               op_a, op_b, res;
   logic                         op_div;
   logic [akf_pkg::WORD_W:0]     mul_sum, div_shift, div_trial;
   akf_pkg::q_type               dt_q, qa_q, qb_q, rn_q;

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_axis_out  = rsp_axis_ff;
   assign rsp_angle_est = rsp_angle_ff;
   assign rsp_rate_est  = rsp_rate_ff;

   assign dt_q = akf_pkg::q_type'({{(akf_pkg::WORD_W-akf_pkg::DT_W){1'b0}}, dt_ff});
   assign qa_q = akf_pkg::q_type'({1'b0, qa_ff});
   assign qb_q = akf_pkg::q_type'({1'b0, qb_ff});
   assign rn_q = akf_pkg::q_type'({1'b0, rn_ff});

   assign ax_in = (int'(req_axis) >= akf_pkg::NUM_AXES) ?
                  akf_pkg::AXIS_W'(akf_pkg::NUM_AXES - 1) : req_axis;

   always_comb begin
      op_a   = '0;
      op_b   = dt_q;
      op_div = 1'b0;
      unique case (op_ff)
         OP_ANG: op_a = akf_pkg::qsub(gyro_ff, bias_ff);
         OP_PAA: op_a = akf_pkg::qsub(akf_pkg::qsub(qa_q, pab_ff), pba_ff);
         OP_PAB: op_a = akf_pkg::qsub('0, pbb_ff);
         OP_PBB: op_a = qb_q;
         OP_K0: begin
            op_a = paa_ff; op_b = e_ff; op_div = 1'b1;
         end
         OP_K1: begin
            op_a = pba_ff; op_b = e_ff; op_div = 1'b1;
         end
         OP_C0: begin op_a = k0_ff; op_b = t0_ff;  end
         OP_C1: begin op_a = k0_ff; op_b = t1_ff;  end
         OP_C2: begin op_a = k1_ff; op_b = t0_ff;  end
         OP_C3: begin op_a = k1_ff; op_b = t1_ff;  end
         OP_C4: begin op_a = k0_ff; op_b = err_ff; end
         OP_C5: begin op_a = k1_ff; op_b = err_ff; end
         default: op_a = '0;
      endcase
   end

   always_comb begin
      mul_sum   = hi_ff + (lo_ff[0] ? {1'b0, opnd_ff} : '0);
      div_shift = {rem_ff, quo_ff[akf_pkg::MAG_W-1]};
      div_trial = div_shift - {1'b0, opnd_ff};
      if (div_ff) begin
         res = den_zero_ff ? '0 : akf_pkg::sat_mag(quo_ff, neg_ff);
      end else begin
         res = akf_pkg::sat_mag({hi_ff[akf_pkg::WORD_W-1:0], lo_ff[akf_pkg::WORD_W-1:16]},
                                neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ANG;
         rsp_valid_ff <= 1'b0;
         qa_ff        <= akf_pkg::NOISE_RESET;
         qb_ff        <= akf_pkg::NOISE_RESET;
         rn_ff        <= akf_pkg::NOISE_RESET;
         dt_ff        <= akf_pkg::DT_RESET;
         for (int i = 0; i < akf_pkg::NUM_AXES; i++) begin
            ang_mem_ff[i]  <= '0;
            bias_mem_ff[i] <= '0;
            paa_mem_ff[i]  <= akf_pkg::Q_ONE;
            pab_mem_ff[i]  <= '0;
            pba_mem_ff[i]  <= '0;
            pbb_mem_ff[i]  <= akf_pkg::Q_ONE;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               akf_pkg::REG_NOISE_ANGLE: qa_ff <= csr_data[akf_pkg::NOISE_W-1:0];
               akf_pkg::REG_NOISE_BIAS:  qb_ff <= csr_data[akf_pkg::NOISE_W-1:0];
               akf_pkg::REG_MEAS_NOISE:  rn_ff <= csr_data[akf_pkg::NOISE_W-1:0];
               akf_pkg::REG_TIME_STEP:   dt_ff <= csr_data[akf_pkg::DT_W-1:0];
               default:                  dt_ff <= dt_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_WB)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff    <= ax_in;
                  meas_ff  <= req_angle_meas;
                  gyro_ff  <= req_gyro_meas;
                  ang_ff   <= ang_mem_ff[ax_in];
                  bias_ff  <= bias_mem_ff[ax_in];
                  paa_ff   <= paa_mem_ff[ax_in];
                  pab_ff   <= pab_mem_ff[ax_in];
                  pba_ff   <= pba_mem_ff[ax_in];
                  pbb_ff   <= pbb_mem_ff[ax_in];
                  op_ff    <= OP_ANG;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               div_ff      <= op_div;
               neg_ff      <= op_a[akf_pkg::WORD_W-1] ^ op_b[akf_pkg::WORD_W-1];
               den_zero_ff <= (op_b == '0);
               opnd_ff     <= op_div ? akf_pkg::mag(op_b) : akf_pkg::mag(op_a);
               hi_ff       <= '0;
               lo_ff       <= akf_pkg::mag(op_b);
               rem_ff      <= '0;
               quo_ff      <= {akf_pkg::mag(op_a), 16'b0};
               cnt_ff      <= op_div ? akf_pkg::CNT_W'(akf_pkg::DIV_CYCLES - 1) :
                                       akf_pkg::CNT_W'(akf_pkg::MUL_CYCLES - 1);
               state_ff    <= S_RUN;
            end
            S_RUN: begin
               if (div_ff) begin
                  if (!div_trial[akf_pkg::WORD_W]) begin
                     rem_ff <= div_trial[akf_pkg::WORD_W-1:0];
                  end else begin
                     rem_ff <= div_shift[akf_pkg::WORD_W-1:0];
                  end
                  quo_ff <= {quo_ff[akf_pkg::MAG_W-2:0], ~div_trial[akf_pkg::WORD_W]};
               end else begin
                  hi_ff <= {1'b0, mul_sum[akf_pkg::WORD_W:1]};
                  lo_ff <= {mul_sum[0], lo_ff[akf_pkg::WORD_W-1:1]};
               end
               if (cnt_ff == '0) begin
                  state_ff <= S_APPLY;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_APPLY: begin
               if (op_ff == OP_C5) begin
                  state_ff <= S_WB;
               end else begin
                  state_ff <= S_LOAD;
               end
               unique case (op_ff)
                  OP_ANG: begin
                     ang_ff <= akf_pkg::qadd(ang_ff, res); op_ff <= OP_PAA;
                  end
                  OP_PAA: begin
                     paa_ff <= akf_pkg::qadd(paa_ff, res); op_ff <= OP_PAB;
                  end
                  OP_PAB: begin
                     pab_ff <= akf_pkg::qadd(pab_ff, res);
                     pba_ff <= akf_pkg::qadd(pba_ff, res);
                     op_ff  <= OP_PBB;
                  end
                  OP_PBB: begin
                     pbb_ff <= akf_pkg::qadd(pbb_ff, res);
                     err_ff <= akf_pkg::qsub(meas_ff, ang_ff);
                     e_ff   <= akf_pkg::qadd(rn_q, paa_ff);
                     t0_ff  <= paa_ff;
                     t1_ff  <= pab_ff;
                     op_ff  <= OP_K0;
                  end
                  OP_K0: begin k0_ff <= res; op_ff <= OP_K1; end
                  OP_K1: begin k1_ff <= res; op_ff <= OP_C0; end
                  OP_C0: begin
                     paa_ff <= akf_pkg::qsub(paa_ff, res); op_ff <= OP_C1;
                  end
                  OP_C1: begin
                     pab_ff <= akf_pkg::qsub(pab_ff, res); op_ff <= OP_C2;
                  end
                  OP_C2: begin
                     pba_ff <= akf_pkg::qsub(pba_ff, res); op_ff <= OP_C3;
                  end
                  OP_C3: begin
                     pbb_ff <= akf_pkg::qsub(pbb_ff, res); op_ff <= OP_C4;
                  end
                  OP_C4: begin
                     ang_ff <= akf_pkg::qadd(ang_ff, res); op_ff <= OP_C5;
                  end
                  OP_C5: begin
                     bias_ff <= akf_pkg::qadd(bias_ff, res);
                  end
                  default: op_ff <= OP_ANG;
               endcase
            end
            S_WB: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_axis_ff        <= ax_ff;
                  rsp_angle_ff       <= ang_ff;
                  rsp_rate_ff        <= akf_pkg::qsub(gyro_ff, bias_ff);
                  ang_mem_ff[ax_ff]  <= ang_ff;
                  bias_mem_ff[ax_ff] <= bias_ff;
                  paa_mem_ff[ax_ff]  <= paa_ff;
                  pab_mem_ff[ax_ff]  <= pab_ff;
                  pba_mem_ff[ax_ff]  <= pba_ff;
                  pbb_mem_ff[ax_ff]  <= pbb_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_wb_delivers, clock, reset,
                (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready),
                rsp_valid_ff && (state_ff == S_IDLE))
   `ASSERT_IMPLY(a_run_has_count, clock, reset,
                 (state_ff == S_RUN) && !div_ff,
                 cnt_ff < akf_pkg::CNT_W'(akf_pkg::MUL_CYCLES))

endmodule
